FILE: sv/mm4_pkg.sv
// Shared types and constants of the fixed-point 4x4 matrix multiplier.
package mm4_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;

   localparam int ELEM_W = 32;
   localparam int ROW_W  = 2;
   localparam int ACT_W  = 2;
   localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int ADDR_W = $clog2(DIM * DIM);
   localparam int PROD_W = 2 * ELEM_W;
   localparam int ACC_W  = PROD_W + $clog2(DIM);
   localparam int SHR_W  = ACC_W - FRAC_BITS;

   localparam logic [ELEM_W-1:0] ONE_VAL = ELEM_W'(1) << FRAC_BITS;

   localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MUL   = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // One element write into either matrix.
   typedef struct packed {
      logic              en;
      logic              sel_right;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [ELEM_W-1:0] data;
   } wr_type;

   // One dot-product term issued to the multiply-accumulate unit.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_term;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] k;
   } term_type;

endpackage

FILE: sv/matrix_multiply_4x4_top.sv
// Top level of the signed Q16.16 4x4 matrix multiplier.
//
//   Channel   Direction  Ports                          Contents
//   req       in         req_tvalid/tready/tdata/tuser  load or compute word
//   rsp       out        rsp_tvalid/tready/tdata/tuser  one product element
//                        rsp_tlast                      marks the last element
//
// A load word writes one element of the left or the right matrix. A compute
// word occupies the block until all its terms are issued: one shared 32 by
// 32 multiplier takes one dot-product term per cycle unless results stall,
// four terms per element, and each element passes the multiply, accumulate
// and output registers after its last term. Reset puts both matrices back
// to the identity and empties the pipeline. When a result word waits and is
// not taken, the multiplier, accumulator and counters hold until it is.
module matrix_multiply_4x4_top
   import mm4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row [1:0], col [3:2], element [35:4], zero [39:36]
   input  logic [1:0]  req_tuser,   // action [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_row [1:0], out_col [3:2], product [35:4], zero [39:36]
   output logic        rsp_tuser,   // saturated [0]
   output logic        rsp_tlast
);

   wr_type            wr;
   term_type          term;
   logic              advance;
   logic [ELEM_W-1:0] left_rd;
   logic [ELEM_W-1:0] right_rd;

   // The sequencer decodes each word and steps through the terms.
   mm4_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .wr         (wr),
      .term       (term)
   );

   // Both matrices, read once each per cycle at the current term.
   mm4_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .term     (term),
      .left_rd  (left_rd),
      .right_rd (right_rd)
   );

   // Multiply, accumulate, shift and saturate, then the output register.
   mm4_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .term       (term),
      .left_rd    (left_rd),
      .right_rd   (right_rd),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/mm4_store.sv
// Left and right matrix stores, reset to the identity, one read per matrix.
module mm4_store
   import mm4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  wr_type            wr,
   input  term_type          term,
   output logic [ELEM_W-1:0] left_rd,
   output logic [ELEM_W-1:0] right_rd
);

   logic [ELEM_W-1:0] left_ff  [DIM*DIM];
   logic [ELEM_W-1:0] right_ff [DIM*DIM];

   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] left_addr;
   logic [ADDR_W-1:0] right_addr;

   assign wr_addr    = ADDR_W'(wr.row) * ADDR_W'(DIM) + ADDR_W'(wr.col);
   assign left_addr  = ADDR_W'(term.row) * ADDR_W'(DIM) + ADDR_W'(term.k);
   assign right_addr = ADDR_W'(term.k) * ADDR_W'(DIM) + ADDR_W'(term.col);

   assign left_rd  = left_ff[left_addr];
   assign right_rd = right_ff[right_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               left_ff[r*DIM+c]  <= (r == c) ? ONE_VAL : '0;
               right_ff[r*DIM+c] <= (r == c) ? ONE_VAL : '0;
            end
         end
      end else if (wr.en) begin
         if (wr.sel_right) begin
            right_ff[wr_addr] <= wr.data;
         end else begin
            left_ff[wr_addr] <= wr.data;
         end
      end
   end

endmodule

FILE: sv/mm4_mac.sv
// Shared multiply-accumulate unit with shift, saturation and output register.
module mm4_mac
   import mm4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  term_type          term,
   input  logic [ELEM_W-1:0] left_rd,
   input  logic [ELEM_W-1:0] right_rd,
   output logic              advance,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   // Multiply stage.
   logic                     p_valid_ff;
   logic                     p_first_ff;
   logic                     p_last_term_ff;
   logic                     p_last_elem_ff;
   logic [IDX_W-1:0]         p_row_ff;
   logic [IDX_W-1:0]         p_col_ff;
   logic signed [PROD_W-1:0] p_prod_ff;

   // Accumulate stage.
   logic                     a_done_ff;
   logic                     a_last_elem_ff;
   logic [IDX_W-1:0]         a_row_ff;
   logic [IDX_W-1:0]         a_col_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // Output register.
   logic                     o_valid_ff;
   logic [ROW_W-1:0]         o_row_ff;
   logic [ROW_W-1:0]         o_col_ff;
   logic [ELEM_W-1:0]        o_prod_ff;
   logic                     o_sat_ff;
   logic                     o_last_ff;

   logic signed [ACC_W-1:0]  acc_base;
   logic signed [SHR_W-1:0]  shifted;
   logic                     fits;
   logic [ELEM_W-1:0]        sat_val;

   assign advance  = !o_valid_ff || rsp_tready;
   assign acc_base = p_first_ff ? '0 : acc_ff;

   always_comb begin
      shifted = SHR_W'(acc_ff >>> FRAC_BITS);
      fits    = (shifted[SHR_W-1:ELEM_W-1] == '0) || (shifted[SHR_W-1:ELEM_W-1] == '1);
      if (fits) begin
         sat_val = shifted[ELEM_W-1:0];
      end else if (shifted[SHR_W-1]) begin
         sat_val = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         a_done_ff  <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= term.valid;
         a_done_ff  <= p_valid_ff && p_last_term_ff;
         if (a_done_ff) begin
            o_valid_ff <= 1'b1;
         end else begin
            o_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_first_ff     <= term.first;
         p_last_term_ff <= term.last_term;
         p_last_elem_ff <= term.last_elem;
         p_row_ff       <= term.row;
         p_col_ff       <= term.col;
         p_prod_ff      <= $signed(left_rd) * $signed(right_rd);
         if (p_valid_ff) begin
            acc_ff         <= acc_base + ACC_W'(p_prod_ff);
            a_last_elem_ff <= p_last_elem_ff;
            a_row_ff       <= p_row_ff;
            a_col_ff       <= p_col_ff;
         end
         if (a_done_ff) begin
            o_row_ff  <= ROW_W'(a_row_ff);
            o_col_ff  <= ROW_W'(a_col_ff);
            o_prod_ff <= sat_val;
            o_sat_ff  <= !fits;
            o_last_ff <= a_last_elem_ff;
         end
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {4'd0, o_prod_ff, o_col_ff, o_row_ff};
   assign rsp_tuser  = o_sat_ff;
   assign rsp_tlast  = o_last_ff;

endmodule

FILE: sv/mm4_seq.sv
// Sequencer: decodes request words and walks the row, column and term counters.
module mm4_seq
   import mm4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             advance,
   output wr_type           wr,
   output term_type         term
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic [IDX_W-1:0] k_ff, k_in;

   logic [ACT_W-1:0] action;
   logic [ROW_W-1:0] row;
   logic [ROW_W-1:0] col;
   logic             accept;
   logic             k_end;
   logic             c_end;
   logic             r_end;

   assign action = req_tuser;
   assign row    = req_tdata[1:0];
   assign col    = req_tdata[3:2];
   assign k_end  = (k_ff == IDX_W'(DIM - 1));
   assign c_end  = (c_ff == IDX_W'(DIM - 1));
   assign r_end  = (r_ff == IDX_W'(DIM - 1));

   always_comb begin
      state_in   = state_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      req_tready = 1'b0;
      wr.en        = 1'b0;
      wr.sel_right = (action == ACT_RIGHT);
      wr.row       = IDX_W'(row);
      wr.col       = IDX_W'(col);
      wr.data      = req_tdata[35:4];
      accept     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            unique case (action) inside
               ACT_LEFT, ACT_RIGHT: begin
                  wr.en = accept && (int'(row) < DIM) && (int'(col) < DIM);
               end
               ACT_MUL: begin
                  if (accept) begin
                     state_in = ST_RUN;
                     r_in     = '0;
                     c_in     = '0;
                     k_in     = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RUN: begin
            if (advance) begin
               k_in = k_ff + IDX_W'(1);
               if (k_end) begin
                  k_in = '0;
                  c_in = c_ff + IDX_W'(1);
                  if (c_end) begin
                     c_in = '0;
                     r_in = r_ff + IDX_W'(1);
                     if (r_end) begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign term.valid     = (state_ff == ST_RUN);
   assign term.first     = (k_ff == '0);
   assign term.last_term = k_end;
   assign term.last_elem = r_end && c_end;
   assign term.row       = r_ff;
   assign term.col       = c_ff;
   assign term.k         = k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

endmodule

FILE: tb/sv/matrix_multiply_4x4_top_tb.sv
// Self-checking testbench for the signed Q16.16 4x4 matrix multiplier.
`timescale 1ns / 100ps

module matrix_multiply_4x4_top_tb
   import mm4_pkg::*;
();

   // The fourth action code has no meaning in the block and must be ignored.
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

   localparam logic [ELEM_W-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic [ELEM_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam int HOLD_CYCLES   = 300;   // the long receiver hold-off
   localparam int MAX_GAP       = 30;    // longest sender idle gap
   localparam int STALL_LIMIT   = 3000;  // cycles without any accepted word
   localparam int DRAIN_CYCLES  = 20;    // settling time once all is checked
   localparam int PHASE_WORDS   = 98;

   // One expected or observed product element.
   typedef struct {
      logic [ROW_W-1:0]  row;
      logic [ROW_W-1:0]  col;
      logic [ELEM_W-1:0] value;
      logic              sat;
      logic              last;
   } elem_type;

   // Keeps a private copy of both matrices, works out every product element
   // when a compute word is accepted and matches the result words in order.
   class product_checker;
      logic [ELEM_W-1:0] left_m  [DIM][DIM];
      logic [ELEM_W-1:0] right_m [DIM][DIM];
      elem_type          awaited_elems[$];
      int                errors;
      int                words_seen;
      int                product_runs;
      int                elems_checked;

      function new();
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               left_m[r][c]  = (r == c) ? ONE_VAL : '0;
               right_m[r][c] = (r == c) ? ONE_VAL : '0;
            end
         end
      endfunction

      // Exact four-term dot product, arithmetic shift, then clamp to 32 bits.
      function elem_type dot_element(int r, int c);
         logic signed [71:0] acc;
         logic signed [71:0] a;
         logic signed [71:0] b;
         logic signed [71:0] shifted;
         elem_type           e;
         acc = '0;
         for (int k = 0; k < DIM; k++) begin
            a = $signed(left_m[r][k]);
            b = $signed(right_m[k][c]);
            acc = acc + a * b;
         end
         shifted = acc >>> FRAC_BITS;
         e.row  = ROW_W'(r);
         e.col  = ROW_W'(c);
         e.last = (r == DIM - 1) && (c == DIM - 1);
         if (shifted > 72'sh7FFF_FFFF) begin
            e.value = MOST_POS;
            e.sat   = 1'b1;
         end else if (shifted < -72'sh8000_0000) begin
            e.value = MOST_NEG;
            e.sat   = 1'b1;
         end else begin
            e.value = shifted[ELEM_W-1:0];
            e.sat   = 1'b0;
         end
         return e;
      endfunction

      function void note_request(logic [ACT_W-1:0] act, logic [ROW_W-1:0] row,
                                 logic [ROW_W-1:0] col, logic [ELEM_W-1:0] elem);
         words_seen++;
         case (act)
            ACT_LEFT: begin
               if (row < DIM && col < DIM) left_m[row][col] = elem;
            end
            ACT_RIGHT: begin
               if (row < DIM && col < DIM) right_m[row][col] = elem;
            end
            ACT_MUL: begin
               product_runs++;
               for (int r = 0; r < DIM; r++)
                  for (int c = 0; c < DIM; c++)
                     awaited_elems.push_back(dot_element(r, c));
            end
            default: ;
         endcase
      endfunction

      function void check_element(elem_type got);
         elem_type want;
         elems_checked++;
         if (awaited_elems.size() == 0) begin
            $error("product element (%0d,%0d) = %h arrived with nothing awaited",
                   got.row, got.col, got.value);
            errors++;
            return;
         end
         want = awaited_elems.pop_front();
         if (got.row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row);
            errors++;
         end
         if (got.col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, got.col);
            errors++;
         end
         if (got.value !== want.value) begin
            $error("product (%0d,%0d): expected %h, got %h",
                   want.row, want.col, want.value, got.value);
            errors++;
         end
         if (got.sat !== want.sat) begin
            $error("saturated (%0d,%0d): expected %b, got %b",
                   want.row, want.col, want.sat, got.sat);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last (%0d,%0d): expected %b, got %b",
                   want.row, want.col, want.last, got.last);
            errors++;
         end
      endfunction

      function int awaited();
         return awaited_elems.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // row [1:0], col [3:2], element [35:4], zero [39:36]
   logic [1:0]  req_tuser;   // action [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // out_row [1:0], out_col [3:2], product [35:4], zero [39:36]
   logic        rsp_tuser;   // saturated [0]
   logic        rsp_tlast;

   product_checker chk;

   // Traffic shaping, set by the stimulus process between phases.
   int idle_pct;
   int stall_pct;
   bit hold_pending;
   int quiet_cycles;

   matrix_multiply_4x4_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls at the current rate, plus one long hold-off on
   // request. The hold-off is counted here so that the sender carries on
   // offering words while the result side is blocked, which fills the
   // pipeline and must eventually stall the request side.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Monitor: every accepted word on either side is handed to the checker.
   // Signals are sampled at the edge, before any nonblocking update lands.
   // The same process runs the watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      elem_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            chk.note_request(req_tuser, req_tdata[1:0], req_tdata[3:2],
                             req_tdata[35:4]);
         if (rsp_tvalid && rsp_tready) begin
            got.row   = rsp_tdata[1:0];
            got.col   = rsp_tdata[3:2];
            got.value = rsp_tdata[35:4];
            got.sat   = rsp_tuser;
            got.last  = rsp_tlast;
            chk.check_element(got);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d elements awaited",
                     STALL_LIMIT, chk.awaited());
            $display("Simulation FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offers one request word, after a random idle gap at the current rate,
   // and returns at the edge where it is accepted. Valid is only lowered when
   // a gap really follows, so it is never dropped and raised in one step.
   task automatic send_word(logic [ACT_W-1:0] act, logic [ROW_W-1:0] row,
                            logic [ROW_W-1:0] col, logic [ELEM_W-1:0] elem);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0000, elem, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Element values: half of them modest Q16.16 numbers, so that products stay in
   // range, with the extremes, zero, one and fully random patterns mixed in.
   function automatic logic [ELEM_W-1:0] pick_element();
      int v;
      case ($urandom_range(11))
         0:       return MOST_POS;
         1:       return MOST_NEG;
         2:       return '0;
         3:       return ONE_VAL;
         4, 5:    return $urandom();
         default: begin
            v = int'($urandom_range(0, 1048575)) - 524288;
            return v;
         end
      endcase
   endfunction

   // Random word: mostly element loads, with a compute now and then and the
   // odd word carrying the unused action code.
   task automatic send_random_word();
      int dice;
      logic [ACT_W-1:0] act;
      dice = $urandom_range(99);
      if (dice < 3)
         act = ACT_NONE;
      else if (dice < 11)
         act = ACT_MUL;
      else
         act = $urandom_range(1) ? ACT_RIGHT : ACT_LEFT;
      send_word(act, ROW_W'($urandom_range(3)), ROW_W'($urandom_range(3)),
                pick_element());
   endtask

   initial begin
      int idle_set  [4] = '{0, 61, 0, 27};
      int stall_set [4] = '{0, 0, 61, 27};

      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = ACT_LEFT;
      idle_pct     = 0;
      stall_pct    = 0;
      hold_pending = 1'b0;
      quiet_cycles = 0;
      chk          = new();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Both matrices start as the identity, so the first
      // product is the identity itself. A word with the unused action must
      // change nothing.
      send_word(ACT_MUL, 2'd0, 2'd0, '0);
      send_word(ACT_NONE, 2'd3, 2'd3, ALL_ONES);
      // Row 0 of the left and column 0 of the right set to the most negative
      // value: the sum of four such products overflows upwards.
      for (int k = 0; k < DIM; k++) send_word(ACT_LEFT, 2'd0, ROW_W'(k), MOST_NEG);
      for (int k = 0; k < DIM; k++) send_word(ACT_RIGHT, ROW_W'(k), 2'd0, MOST_NEG);
      // A tiny extra term pushes element (0,1) just below the lower bound,
      // while (0,2) lands exactly on it without clamping.
      send_word(ACT_RIGHT, 2'd2, 2'd1, 32'h0000_0001);
      // The largest value times one is exact at the upper bound; times the
      // most negative right element it clamps at the bottom.
      send_word(ACT_LEFT, 2'd3, 2'd3, MOST_POS);
      send_word(ACT_LEFT, 2'd1, 2'd1, ALL_ONES);
      // One half times minus one unit: the shift rounds towards minus
      // infinity and gives minus one unit rather than zero.
      send_word(ACT_LEFT, 2'd2, 2'd2, 32'h0000_8000);
      send_word(ACT_RIGHT, 2'd2, 2'd3, ALL_ONES);
      send_word(ACT_MUL, 2'd3, 2'd3, ALL_ONES);
      send_word(ACT_NONE, 2'd0, 2'd0, '0);
      send_word(ACT_RIGHT, 2'd3, 2'd2, 32'h5555_AAAA);
      send_word(ACT_LEFT, 2'd2, 2'd3, 32'hAAAA_5555);
      send_word(ACT_MUL, 2'd1, 2'd2, 32'h1234_5678);

      // Random phases with different idle and stall rates. The first phase
      // opens with the long receiver hold-off while computes keep coming.
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_set[ph];
         stall_pct = stall_set[ph];
         if (ph == 0) begin
            hold_pending = 1'b1;
            send_word(ACT_MUL, 2'd0, 2'd0, '0);
            send_word(ACT_MUL, 2'd0, 2'd0, '0);
         end
         for (int n = 0; n < PHASE_WORDS; n++) send_random_word();
      end
      req_tvalid <= 1'b0;

      // Let every awaited element arrive; the watchdog bounds this wait.
      while (chk.awaited() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request words with %0d product runs and %0d elements checked,",
               chk.words_seen, chk.product_runs, chk.elems_checked);
      $display("across idle-free, sender-idle, receiver-stall and mixed phases plus a long hold-off.");
      if (chk.errors == 0 && chk.awaited() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
